>>> rtl/tfr_pkg.sv
// Shared types and constants for the timestamped frame ring.
`timescale 1ns / 1ps

package tfr_pkg;

   localparam int MODE_W   = 3;
   localparam int HANDLE_W = 32;
   localparam int TIME_W   = 64;
   localparam int AGE_W    = 4;
   localparam int HELD_W   = 5;

   // Operation codes carried in the mode field.
   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH   = 3'd0,
      MODE_LATEST = 3'd1,
      MODE_TIME   = 3'd2,
      MODE_INDEX  = 3'd3,
      MODE_CLEAR  = 3'd4
   } mode_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SCAN
   } state_type;

   // One stored ring entry.
   typedef struct packed {
      logic        [HANDLE_W-1:0] frame_handle;
      logic signed [TIME_W-1:0]   frame_time;
   } entry_type;

endpackage

>>> rtl/tfr_ifs.sv
// Request and response channel interfaces for the timestamped frame ring.
`timescale 1ns / 1ps

interface tfr_req_if;
   logic                                valid;
   logic                                ready;
   logic        [tfr_pkg::MODE_W-1:0]   mode;
   logic        [tfr_pkg::HANDLE_W-1:0] frame_handle;
   logic signed [tfr_pkg::TIME_W-1:0]   frame_time;
   logic        [tfr_pkg::AGE_W-1:0]    age_position;

   modport source (output valid, mode, frame_handle, frame_time, age_position, input ready);
   modport sink   (input valid, mode, frame_handle, frame_time, age_position, output ready);
endinterface

interface tfr_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                found;
   logic        [tfr_pkg::HANDLE_W-1:0] result_handle;
   logic signed [tfr_pkg::TIME_W-1:0]   result_time;
   logic        [tfr_pkg::HELD_W-1:0]   held_count;

   modport source (output valid, found, result_handle, result_time, held_count, input ready);
   modport sink   (input valid, found, result_handle, result_time, held_count, output ready);
endinterface

>>> rtl/tfr_mem.sv
// Entry memory: one write port and one read port with registered read data.
`timescale 1ns / 1ps

module tfr_mem #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  tfr_pkg::entry_type wr_data,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  rd_addr,
   output tfr_pkg::entry_type rd_data
);

   tfr_pkg::entry_type entry_mem [DEPTH];
   tfr_pkg::entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
   end

   // Read port with registered read data, held while rd_en is low.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/timestamped_frame_ring.sv
// Timestamped frame ring: control, ring pointers and result register around the entry memory.
// Push, clear, unused codes and lookups answered without a memory read load the result register on
// acceptance. Latest and index hits take one memory read, then the result register.
// A timestamp lookup reads one entry per cycle from the oldest.
// One item is in work at a time; a new item is taken when the result register is free or drains.
// Synchronous reset empties the ring; memory contents stay undefined and are never read unwritten.
`timescale 1ns / 1ps

module timestamped_frame_ring #(
   parameter int DEPTH = 16
) (
   input logic       clock,
   input logic       reset,
   tfr_req_if.sink   req_ch,
   tfr_rsp_if.source rsp_ch
);

   localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int WIDE_W = ((CNT_W > tfr_pkg::AGE_W) ? CNT_W : tfr_pkg::AGE_W) + 2;
   localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0]  FULL_CNT   = CNT_W'(DEPTH);
   localparam logic [WIDE_W-1:0] DEPTH_WIDE = WIDE_W'(DEPTH);

   tfr_pkg::state_type state_ff, state_in;
   logic [SLOT_W-1:0]  ws_ff, ws_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SLOT_W-1:0]  rd_slot_ff, rd_slot_in;
   logic [CNT_W-1:0]   left_ff, left_in;
   logic signed [tfr_pkg::TIME_W-1:0] target_ff, target_in;
   logic               hit_ff, hit_in;
   tfr_pkg::entry_type best_ff, best_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_found_ff, rsp_found_in;
   logic        [tfr_pkg::HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic signed [tfr_pkg::TIME_W-1:0]   rsp_time_ff, rsp_time_in;
   logic        [tfr_pkg::HELD_W-1:0]   rsp_held_ff, rsp_held_in;
   logic                                rsp_load;

   logic               wr_en;
   tfr_pkg::entry_type wr_data;
   logic               rd_en;
   logic [SLOT_W-1:0]  rd_addr;
   tfr_pkg::entry_type rd_data;

   logic [WIDE_W-1:0]  oldest_raw, oldest_norm, age_raw, age_norm;
   logic [SLOT_W-1:0]  oldest_slot, age_slot, latest_slot;
   logic               age_hit;
   logic               not_above;
   logic               req_ready;
   logic               req_take;

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
      return (s == LAST_SLOT) ? '0 : s + 1'b1;
   endfunction

   tfr_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (SLOT_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ws_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Physical slots of the oldest entry, the newest entry and the requested age.
   always_comb begin
      oldest_raw  = WIDE_W'(ws_ff) + DEPTH_WIDE - WIDE_W'(cnt_ff);
      oldest_norm = (oldest_raw >= DEPTH_WIDE) ? oldest_raw - DEPTH_WIDE : oldest_raw;
      age_raw     = oldest_norm + WIDE_W'(req_ch.age_position);
      age_norm    = (age_raw >= DEPTH_WIDE) ? age_raw - DEPTH_WIDE : age_raw;
      oldest_slot = oldest_norm[SLOT_W-1:0];
      age_slot    = age_norm[SLOT_W-1:0];
      latest_slot = (ws_ff == '0) ? LAST_SLOT : ws_ff - 1'b1;
      age_hit     = WIDE_W'(req_ch.age_position) < WIDE_W'(cnt_ff);
   end

   assign not_above = $signed(rd_data.frame_time) <= target_ff;
   assign req_ready = (state_ff == tfr_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign req_take  = req_ch.valid && req_ready;

   // Next state, pointer updates, memory accesses and result loading.
   always_comb begin
      state_in      = state_ff;
      ws_in         = ws_ff;
      cnt_in        = cnt_ff;
      rd_slot_in    = rd_slot_ff;
      left_in       = left_ff;
      target_in     = target_ff;
      hit_in        = hit_ff;
      best_in       = best_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_found_in  = rsp_found_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_time_in   = rsp_time_ff;
      rsp_held_in   = rsp_held_ff;
      rsp_load      = 1'b0;
      wr_en         = 1'b0;
      wr_data.frame_handle = req_ch.frame_handle;
      wr_data.frame_time   = req_ch.frame_time;
      rd_en         = 1'b0;
      rd_addr       = oldest_slot;

      case (state_ff)
         tfr_pkg::ST_IDLE: begin
            if (req_take) begin
               // Default answer is a miss; hits below override it.
               rsp_load      = 1'b1;
               rsp_found_in  = 1'b0;
               rsp_handle_in = '0;
               rsp_time_in   = '0;
               case (req_ch.mode)
                  tfr_pkg::MODE_PUSH: begin
                     wr_en        = 1'b1;
                     ws_in        = next_slot(ws_ff);
                     cnt_in       = (cnt_ff != FULL_CNT) ? cnt_ff + 1'b1 : cnt_ff;
                     rsp_found_in = 1'b1;
                  end
                  tfr_pkg::MODE_LATEST: begin
                     if (cnt_ff != '0) begin
                        rsp_load = 1'b0;
                        rd_en    = 1'b1;
                        rd_addr  = latest_slot;
                        state_in = tfr_pkg::ST_READ;
                     end
                  end
                  tfr_pkg::MODE_INDEX: begin
                     if (age_hit) begin
                        rsp_load = 1'b0;
                        rd_en    = 1'b1;
                        rd_addr  = age_slot;
                        state_in = tfr_pkg::ST_READ;
                     end
                  end
                  tfr_pkg::MODE_TIME: begin
                     if (cnt_ff != '0) begin
                        rsp_load   = 1'b0;
                        rd_en      = 1'b1;
                        rd_addr    = oldest_slot;
                        rd_slot_in = next_slot(oldest_slot);
                        left_in    = cnt_ff - 1'b1;
                        target_in  = req_ch.frame_time;
                        hit_in     = 1'b0;
                        state_in   = tfr_pkg::ST_SCAN;
                     end
                  end
                  tfr_pkg::MODE_CLEAR: begin
                     ws_in  = '0;
                     cnt_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         tfr_pkg::ST_READ: begin
            // Read data of a latest or index lookup is back.
            rsp_load      = 1'b1;
            rsp_found_in  = 1'b1;
            rsp_handle_in = rd_data.frame_handle;
            rsp_time_in   = rd_data.frame_time;
            state_in      = tfr_pkg::ST_IDLE;
         end
         tfr_pkg::ST_SCAN: begin
            // Check one entry per cycle while the next read is in flight.
            if (not_above) begin
               hit_in  = 1'b1;
               best_in = rd_data;
            end
            if (not_above && (left_ff != '0)) begin
               rd_en      = 1'b1;
               rd_addr    = rd_slot_ff;
               rd_slot_in = next_slot(rd_slot_ff);
               left_in    = left_ff - 1'b1;
            end else begin
               rsp_load     = 1'b1;
               rsp_found_in = not_above || hit_ff;
               if (not_above) begin
                  rsp_handle_in = rd_data.frame_handle;
                  rsp_time_in   = rd_data.frame_time;
               end else if (hit_ff) begin
                  rsp_handle_in = best_ff.frame_handle;
                  rsp_time_in   = best_ff.frame_time;
               end else begin
                  rsp_handle_in = '0;
                  rsp_time_in   = '0;
               end
               state_in = tfr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tfr_pkg::ST_IDLE;
         end
      endcase

      // Every result reports the count after its operation.
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_held_in  = tfr_pkg::HELD_W'(cnt_in);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tfr_pkg::ST_IDLE;
         ws_ff        <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ws_ff        <= ws_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Scan and result payload registers.
   always_ff @(posedge clock) begin
      rd_slot_ff    <= rd_slot_in;
      left_ff       <= left_in;
      target_ff     <= target_in;
      hit_ff        <= hit_in;
      best_ff       <= best_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_time_ff   <= rsp_time_in;
      rsp_held_ff   <= rsp_held_in;
   end

   assign req_ch.ready         = req_ready;
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.found         = rsp_found_ff;
   assign rsp_ch.result_handle = rsp_handle_ff;
   assign rsp_ch.result_time   = rsp_time_ff;
   assign rsp_ch.held_count    = rsp_held_ff;

   // The count never passes the ring depth.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FULL_CNT)
      else $error("ring count exceeds depth");

   // No new item is taken while a lookup is in work.
   a_busy_block: assert property (@(posedge clock) disable iff (reset)
      (state_ff != tfr_pkg::ST_IDLE) |-> !req_ch.ready)
      else $error("item taken while a lookup is in work");

   // The result register stays empty while a lookup is reading memory.
   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff != tfr_pkg::ST_IDLE) |-> !rsp_valid_ff)
      else $error("result pending during a lookup");

   // A clear leaves an empty ring with the write slot at the start.
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_ch.mode == tfr_pkg::MODE_CLEAR)) |=> ((cnt_ff == '0) && (ws_ff == '0)))
      else $error("clear did not empty the ring");

   // A push always leaves at least one entry.
   a_push: assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_ch.mode == tfr_pkg::MODE_PUSH)) |=> (cnt_ff != '0))
      else $error("push left the ring empty");

endmodule

>>> tb/timestamped_frame_ring_test.sv
// Self-checking testbench for the timestamped frame ring: shadow ring, directed and random traffic.
`timescale 1ns / 1ps

module timestamped_frame_ring_test;

   localparam int RING_DEPTH   = 16;
   localparam int RANDOM_ITEMS = 650;
   localparam int CALM_TAIL    = 120;
   localparam int LONG_HOLD    = 150;
   localparam int DRAIN_CYCLES = 40;
   localparam int QUIET_LIMIT  = 2000;
   localparam int REPORT_CAP   = 10;

   // Mode codes that the block does not use.
   localparam logic [tfr_pkg::MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
   localparam logic [tfr_pkg::MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

   localparam logic signed [tfr_pkg::TIME_W-1:0] TIME_MIN = {1'b1, {(tfr_pkg::TIME_W-1){1'b0}}};
   localparam logic signed [tfr_pkg::TIME_W-1:0] TIME_MAX = {1'b0, {(tfr_pkg::TIME_W-1){1'b1}}};

   typedef struct packed {
      logic        [tfr_pkg::MODE_W-1:0]   mode;
      logic        [tfr_pkg::HANDLE_W-1:0] frame_handle;
      logic signed [tfr_pkg::TIME_W-1:0]   frame_time;
      logic        [tfr_pkg::AGE_W-1:0]    age_position;
   } frame_request_type;

   typedef struct packed {
      logic                                found;
      logic        [tfr_pkg::HANDLE_W-1:0] result_handle;
      logic signed [tfr_pkg::TIME_W-1:0]   result_time;
      logic        [tfr_pkg::HELD_W-1:0]   held_count;
   } frame_answer_type;

   // Shadow copy of the ring; it predicts each answer and checks the block against it.
   class frame_ring_shadow;
      logic        [tfr_pkg::HANDLE_W-1:0] handle_mem [RING_DEPTH];
      logic signed [tfr_pkg::TIME_W-1:0]   stamp_mem  [RING_DEPTH];
      int unsigned                         next_slot;
      int unsigned                         fill;
      frame_answer_type                    awaited [$];
      int unsigned                         mismatches;
      int unsigned                         answers_seen;

      function new();
         next_slot    = 0;
         fill         = 0;
         mismatches   = 0;
         answers_seen = 0;
      endfunction

      // Physical slot of the entry at a given age, counted from the oldest.
      function int unsigned slot_of_age(int unsigned age);
         return (next_slot + RING_DEPTH - fill + age) % RING_DEPTH;
      endfunction

      // Timestamp stored at a given age; the caller keeps age below fill.
      function logic signed [tfr_pkg::TIME_W-1:0] stamp_at_age(int unsigned age);
         return stamp_mem[slot_of_age(age)];
      endfunction

      // Apply one accepted item to the shadow ring and queue the answer it should give.
      function void note_request(frame_request_type r);
         frame_answer_type                  ans;
         logic signed [tfr_pkg::TIME_W-1:0] target;
         int unsigned                       i;
         int unsigned                       s;
         int unsigned                       pick;
         bit                                hit;
         ans    = '0;
         hit    = 1'b0;
         pick   = 0;
         target = r.frame_time;
         case (r.mode)
            tfr_pkg::MODE_PUSH: begin
               handle_mem[next_slot] = r.frame_handle;
               stamp_mem[next_slot]  = r.frame_time;
               next_slot = (next_slot + 1) % RING_DEPTH;
               if (fill < RING_DEPTH) fill++;
               ans.found = 1'b1;
            end
            tfr_pkg::MODE_LATEST: begin
               if (fill != 0) begin
                  pick = (next_slot + RING_DEPTH - 1) % RING_DEPTH;
                  hit  = 1'b1;
               end
            end
            tfr_pkg::MODE_TIME: begin
               // Walk from the oldest entry; stop at the first one later than the target.
               for (i = 0; i < fill; i++) begin
                  s = slot_of_age(i);
                  if (stamp_mem[s] > target) break;
                  pick = s;
                  hit  = 1'b1;
               end
            end
            tfr_pkg::MODE_INDEX: begin
               if (r.age_position < fill) begin
                  pick = slot_of_age(r.age_position);
                  hit  = 1'b1;
               end
            end
            tfr_pkg::MODE_CLEAR: begin
               next_slot = 0;
               fill      = 0;
            end
            default: begin
            end
         endcase
         if (hit) begin
            ans.found         = 1'b1;
            ans.result_handle = handle_mem[pick];
            ans.result_time   = stamp_mem[pick];
         end
         ans.held_count = tfr_pkg::HELD_W'(fill);
         awaited.push_back(ans);
      endfunction

      // Compare one accepted result with the oldest expectation.
      function void check_answer(frame_answer_type got);
         frame_answer_type want;
         answers_seen++;
         if (awaited.size() == 0) begin
            if (mismatches < REPORT_CAP)
               $display("result %0d arrived with nothing expected: %s %0b %0h %0d %0d",
                        answers_seen, "found handle time held", got.found,
                        got.result_handle, got.result_time, got.held_count);
            mismatches++;
            return;
         end
         want = awaited.pop_front();
         if (got.found !== want.found || got.result_handle !== want.result_handle ||
             got.result_time !== want.result_time || got.held_count !== want.held_count) begin
            if (mismatches < REPORT_CAP) begin
               $display("result %0d mismatch: expected found %0b handle %h time %0d held %0d",
                        answers_seen, want.found, want.result_handle, want.result_time,
                        want.held_count);
               $display("result %0d mismatch: actual   found %0b handle %h time %0d held %0d",
                        answers_seen, got.found, got.result_handle, got.result_time,
                        got.held_count);
            end
            mismatches++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   tfr_req_if req_ch ();
   tfr_rsp_if rsp_ch ();

   timestamped_frame_ring #(
      .DEPTH (RING_DEPTH)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   frame_ring_shadow shadow = new();

   bit                                sender_gaps_on;
   bit                                receiver_gaps_on;
   bit                                hold_request;
   logic signed [tfr_pkg::TIME_W-1:0] time_cursor;

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic frame_request_type make_request(logic [tfr_pkg::MODE_W-1:0] m,
                                                      logic [tfr_pkg::HANDLE_W-1:0] h,
                                                      logic signed [tfr_pkg::TIME_W-1:0] t,
                                                      logic [tfr_pkg::AGE_W-1:0] a);
      frame_request_type r;
      r.mode         = m;
      r.frame_handle = h;
      r.frame_time   = t;
      r.age_position = a;
      return r;
   endfunction

   // Random item: mostly pushes with rising timestamps and lookups aimed at stored entries.
   function automatic frame_request_type random_request();
      frame_request_type r;
      int unsigned       pick;
      r.mode         = tfr_pkg::MODE_PUSH;
      r.frame_handle = $urandom;
      r.frame_time   = {$urandom, $urandom};
      r.age_position = tfr_pkg::AGE_W'($urandom_range(0, RING_DEPTH - 1));
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         r.mode = tfr_pkg::MODE_PUSH;
         if ($urandom_range(0, 9) != 0) begin
            time_cursor  = time_cursor + $urandom_range(0, 100);
            r.frame_time = time_cursor;
         end
      end else if (pick < 55) begin
         r.mode = tfr_pkg::MODE_LATEST;
      end else if (pick < 77) begin
         r.mode = tfr_pkg::MODE_TIME;
         pick = $urandom_range(0, 9);
         if (pick < 3 && shadow.fill != 0)
            r.frame_time = shadow.stamp_at_age($urandom_range(0, shadow.fill - 1));
         else if (pick < 9)
            r.frame_time = time_cursor - $urandom_range(0, 2000);
      end else if (pick < 93) begin
         r.mode = tfr_pkg::MODE_INDEX;
         if ($urandom_range(0, 2) != 0 && shadow.fill != 0)
            r.age_position = tfr_pkg::AGE_W'($urandom_range(0, shadow.fill - 1));
      end else if (pick < 95) begin
         r.mode = tfr_pkg::MODE_CLEAR;
      end else begin
         r.mode = tfr_pkg::MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
      end
      return r;
   endfunction

   // Offer one item, wait for its handshake, then maybe leave a gap.
   task automatic offer_request(input frame_request_type r);
      req_ch.valid        <= 1'b1;
      req_ch.mode         <= r.mode;
      req_ch.frame_handle <= r.frame_handle;
      req_ch.frame_time   <= r.frame_time;
      req_ch.age_position <= r.age_position;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      shadow.note_request(r);
      if (sender_gaps_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   // Stimulus: reset, directed items, random items, then drain.
   initial begin
      frame_request_type r;
      int unsigned       n;
      bit                pressure_done;
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.mode         <= tfr_pkg::MODE_PUSH;
      req_ch.frame_handle <= '0;
      req_ch.frame_time   <= '0;
      req_ch.age_position <= '0;
      sender_gaps_on   = 1'b0;
      receiver_gaps_on = 1'b0;
      hold_request     = 1'b0;
      pressure_done    = 1'b0;
      time_cursor      = {$urandom, $urandom};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Lookups on the empty ring.
      offer_request(make_request(tfr_pkg::MODE_LATEST, '1, TIME_MAX, '1));
      offer_request(make_request(tfr_pkg::MODE_TIME, '0, '0, '0));
      offer_request(make_request(tfr_pkg::MODE_INDEX, '0, '0, '0));
      // Extreme handles and timestamps, stored out of time order.
      offer_request(make_request(tfr_pkg::MODE_PUSH, '0, '0, '0));
      offer_request(make_request(tfr_pkg::MODE_PUSH, '1, TIME_MAX, '1));
      offer_request(make_request(tfr_pkg::MODE_PUSH, 32'ha5a5_5a5a, TIME_MIN, '0));
      offer_request(make_request(tfr_pkg::MODE_LATEST, '0, '0, '0));
      offer_request(make_request(tfr_pkg::MODE_INDEX, '0, '0, tfr_pkg::AGE_W'(0)));
      offer_request(make_request(tfr_pkg::MODE_INDEX, '0, '0, tfr_pkg::AGE_W'(2)));
      // Positions at and past the count.
      offer_request(make_request(tfr_pkg::MODE_INDEX, '0, '0, tfr_pkg::AGE_W'(3)));
      offer_request(make_request(tfr_pkg::MODE_INDEX, '0, '0, '1));
      // Target below the oldest stamp, equal to it, and at the top of the range.
      offer_request(make_request(tfr_pkg::MODE_TIME, '0, -64'sd1, '0));
      offer_request(make_request(tfr_pkg::MODE_TIME, '0, '0, '0));
      offer_request(make_request(tfr_pkg::MODE_TIME, '0, TIME_MAX, '0));
      // Unused codes leave the ring alone.
      offer_request(make_request(MODE_SPARE_FIRST, '1, TIME_MAX, '1));
      offer_request(make_request(
         tfr_pkg::MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST)), '1, '1, '1));
      offer_request(make_request(MODE_SPARE_LAST, '0, TIME_MIN, '0));
      // Clear, then lookups and a push on the emptied ring.
      offer_request(make_request(tfr_pkg::MODE_CLEAR, '1, TIME_MAX, '1));
      offer_request(make_request(tfr_pkg::MODE_LATEST, '0, '0, '0));
      offer_request(make_request(tfr_pkg::MODE_TIME, '0, TIME_MAX, '0));
      offer_request(make_request(tfr_pkg::MODE_PUSH, 32'h0000_0001, TIME_MIN, '0));
      offer_request(make_request(tfr_pkg::MODE_TIME, '0, TIME_MIN, '0));
      offer_request(make_request(tfr_pkg::MODE_INDEX, '0, '0, '0));

      // Random traffic with idle bursts on both sides; the tail runs without them.
      sender_gaps_on   = 1'b1;
      receiver_gaps_on = 1'b1;
      n = 0;
      while (n < RANDOM_ITEMS) begin
         if (n >= RANDOM_ITEMS - CALM_TAIL) begin
            sender_gaps_on   = 1'b0;
            receiver_gaps_on = 1'b0;
         end
         if (!pressure_done && n >= RANDOM_ITEMS / 2) begin
            hold_request  = 1'b1;
            pressure_done = 1'b1;
         end
         r = random_request();
         offer_request(r);
         n++;
      end
      req_ch.valid <= 1'b0;

      while (shadow.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (shadow.mismatches == 0)
         $display("timestamped_frame_ring_test: done, clean");
      else
         $display("timestamped_frame_ring_test: done, errors");
      $finish;
   end

   // Result side: check each accepted item and stall at random, once for a long stretch.
   initial begin
      int unsigned      hold_left;
      frame_answer_type got;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got.found         = rsp_ch.found;
            got.result_handle = rsp_ch.result_handle;
            got.result_time   = rsp_ch.result_time;
            got.held_count    = rsp_ch.held_count;
            shadow.check_answer(got);
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD;
         end else if (hold_left == 0 && receiver_gaps_on && $urandom_range(0, 5) == 0) begin
            hold_left = $urandom_range(1, 7);
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run when no item moves on either side for too long.
   initial begin
      int unsigned quiet;
      quiet = 0;
      do @(posedge clock); while (reset !== 1'b0);
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
             (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("timestamped_frame_ring_test: done, errors");
      $finish;
   end

endmodule
